// File: rtl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int VALUE_W           = 64;
   localparam int MIN_WIDTH_W       = 6;
   localparam int MAX_CHARS_DEFAULT = 32;
   localparam int DEC_DIGITS        = 20;
   localparam int DIGIT_IDX_W       = 5;
   localparam int CONV_BITS         = 4;
   localparam int CONV_STEPS        = VALUE_W / CONV_BITS;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef struct packed {
      logic [VALUE_W-1:0]     value;
      logic                   signed_mode;
      logic                   radix_hex;
      logic                   upper_case;
      logic [MIN_WIDTH_W-1:0] min_width;
      logic                   pad_zero;
   } itoa_req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } itoa_rsp_type;

   // one classified job, width carried beside it
   typedef struct packed {
      logic [VALUE_W-1:0] magnitude;
      logic               minus;
      logic               hex;
      logic               upper;
      logic               pad_zero;
   } itoa_job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } itoa_qstat_type;

endpackage

// File: rtl/integer_to_ascii_padded_top.sv
`timescale 1ns / 1ps
// channel  | ports                 | handshake
// ---------+-----------------------+-------------------------------------
// request  | push, full, req_data  | transaction when push & !full
// response | empty, pop, rsp_data  | transaction when pop & !empty
//
// decimal: dequeue, conversion (4 bits a cycle of shift-add-3), sizing, then one
//   character per cycle while pop keeps up; hex skips the conversion
// characters leave one per cycle through the output register while pop keeps up, up to MAX_CHARS
// reset (synchronous, active high) empties the job queue and the output register
// a full job queue raises full; a stalled pop holds the back end, not the front

module integer_to_ascii_padded_top import itoa_pkg::*; #(
   parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  itoa_req_type req_data,
   output logic         empty,
   input  logic         pop,
   output itoa_rsp_type rsp_data
);

   // field width counter: holds 0..MAX_CHARS
   localparam int CW = $clog2(MAX_CHARS + 1);

   itoa_job_type   front_job;
   logic [CW-1:0]  front_width;
   itoa_job_type   q_job;
   logic [CW-1:0]  q_width;
   itoa_qstat_type qstat;
   logic           q_pop;

   // front: saturate width, reserve a place for minus, take magnitude, pick radix
   itoa_front #(
      .MAX_CHARS (MAX_CHARS),
      .CW        (CW)
   ) u_front (
      .req_data  (req_data),
      .job       (front_job),
      .job_width (front_width)
   );

   // two-deep job queue decouples acceptance from conversion and emission
   itoa_queue #(
      .CW (CW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push),
      .wr_job   (front_job),
      .wr_width (front_width),
      .rd_en    (q_pop),
      .rd_job   (q_job),
      .rd_width (q_width),
      .stat     (qstat)
   );

   assign full = qstat.full;

   // back: binary to bcd (decimal only), digit count, then one character per cycle while pop keeps up
   itoa_back #(
      .CW (CW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .q_job    (q_job),
      .q_width  (q_width),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/itoa_front.sv
`timescale 1ns / 1ps

module itoa_front import itoa_pkg::*; #(
   parameter int MAX_CHARS = MAX_CHARS_DEFAULT,
   parameter int CW        = $clog2(MAX_CHARS + 1)
) (
   input  itoa_req_type  req_data,
   output itoa_job_type  job,
   output logic [CW-1:0] job_width
);

   logic          negative;
   logic [CW-1:0] width_sat;

   always_comb begin
      negative = req_data.signed_mode & req_data.value[VALUE_W-1];
      if (int'(req_data.min_width) > MAX_CHARS) begin
         width_sat = CW'(MAX_CHARS);
      end else begin
         width_sat = CW'(req_data.min_width);
      end

      job.magnitude = negative ? (~req_data.value + VALUE_W'(1)) : req_data.value;
      job.minus     = negative;
      job.hex       = ~req_data.signed_mode & req_data.radix_hex;
      job.upper     = req_data.upper_case;
      job.pad_zero  = req_data.pad_zero;

      // minus takes one place of the field
      if (negative && (width_sat != '0)) begin
         job_width = width_sat - CW'(1);
      end else begin
         job_width = width_sat;
      end
   end

endmodule

// File: rtl/itoa_queue.sv
`timescale 1ns / 1ps

module itoa_queue import itoa_pkg::*; #(
   parameter int CW = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  itoa_job_type   wr_job,
   input  logic [CW-1:0]  wr_width,
   input  logic           rd_en,
   output itoa_job_type   rd_job,
   output logic [CW-1:0]  rd_width,
   output itoa_qstat_type stat
);

   itoa_job_type  job_ff   [2];
   logic [CW-1:0] width_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_wr, do_rd;

   always_comb begin
      stat.empty = (count_ff == 2'd0);
      stat.full  = (count_ff == 2'd2);
      do_wr      = wr_en & ~stat.full;
      do_rd      = rd_en & ~stat.empty;
      wr_ptr_in  = wr_ptr_ff ^ do_wr;
      rd_ptr_in  = rd_ptr_ff ^ do_rd;
      count_in   = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
      rd_job     = job_ff[rd_ptr_ff];
      rd_width   = width_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         job_ff[wr_ptr_ff]   <= wr_job;
         width_ff[wr_ptr_ff] <= wr_width;
      end
   end

endmodule

// File: rtl/itoa_back.sv
`timescale 1ns / 1ps

module itoa_back import itoa_pkg::*; #(
   parameter int CW = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  itoa_qstat_type qstat,
   input  itoa_job_type   q_job,
   input  logic [CW-1:0]  q_width,
   output logic           q_pop,
   output logic           empty,
   input  logic           pop,
   output itoa_rsp_type   rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_SIZE,
      S_EMIT
   } state_type;

   localparam int STEP_W = $clog2(CONV_STEPS);

   typedef logic [DEC_DIGITS-1:0][3:0] digits_type;

   function automatic digits_type dd_step(input digits_type d, input logic b);
      digits_type a;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         a[i] = (d[i] >= 4'd5) ? (d[i] + 4'd3) : d[i];
      end
      return digits_type'({a[DEC_DIGITS-1:0], b});
   endfunction

   state_type          state_ff, state_in;
   digits_type         digits_ff, digits_in;
   logic [VALUE_W-1:0] shift_ff, shift_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      width_ff, width_in;
   logic               minus_ff, minus_in;
   logic               upper_ff, upper_in;
   logic               pad_ff, pad_in;
   logic               out_valid_ff, out_valid_in;
   itoa_rsp_type       out_ff, out_in;

   digits_type         conv_next;
   logic [CW-1:0]      ndig;
   logic [CW-1:0]      total;
   logic               slot_free;
   logic [3:0]         cur_digit;
   logic [7:0]         cur_char;

   always_comb begin
      conv_next = digits_ff;
      for (int k = 0; k < CONV_BITS; k++) begin
         conv_next = dd_step(conv_next, shift_ff[VALUE_W-1-k]);
      end

      ndig = CW'(1);
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (digits_ff[i] != 4'd0) begin
            ndig = CW'(i + 1);
         end
      end
      total = (ndig > width_ff) ? ndig : width_ff;

      cur_digit = digits_ff[pos_ff[DIGIT_IDX_W-1:0]];
      if (pos_ff >= ndig) begin
         cur_char = pad_ff ? CHAR_ZERO : CHAR_SPACE;
      end else if (cur_digit < 4'd10) begin
         cur_char = CHAR_ZERO + {4'd0, cur_digit};
      end else begin
         cur_char = (upper_ff ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'd0, cur_digit} - 8'd10;
      end
   end

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      shift_in     = shift_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      width_in     = width_ff;
      minus_in     = minus_ff;
      upper_in     = upper_ff;
      pad_in       = pad_ff;
      out_valid_in = out_valid_ff & ~pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      slot_free    = ~out_valid_ff | pop;

      case (state_ff)
         S_IDLE: begin
            if (!qstat.empty) begin
               q_pop    = 1'b1;
               width_in = q_width;
               minus_in = q_job.minus;
               upper_in = q_job.upper;
               pad_in   = q_job.pad_zero;
               step_in  = '0;
               shift_in = q_job.magnitude;
               if (q_job.hex) begin
                  digits_in = digits_type'(q_job.magnitude);
                  state_in  = S_SIZE;
               end else begin
                  digits_in = '0;
                  state_in  = S_CONV;
               end
            end
         end
         S_CONV: begin
            digits_in = conv_next;
            shift_in  = shift_ff << CONV_BITS;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CONV_STEPS - 1)) begin
               state_in = S_SIZE;
            end
         end
         S_SIZE: begin
            width_in = total;
            pos_in   = total - CW'(1);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               if (minus_ff) begin
                  out_in.character = CHAR_MINUS;
                  out_in.last      = 1'b0;
                  minus_in         = 1'b0;
               end else begin
                  out_in.character = cur_char;
                  out_in.last      = (pos_ff == '0);
                  if (pos_ff == '0) begin
                     state_in = S_IDLE;
                  end else begin
                     pos_in = pos_ff - CW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      empty    = ~out_valid_ff;
      rsp_data = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         minus_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         minus_ff     <= minus_in;
      end
      digits_ff <= digits_in;
      shift_ff  <= shift_in;
      step_ff   <= step_in;
      pos_ff    <= pos_in;
      width_ff  <= width_in;
      upper_ff  <= upper_in;
      pad_ff    <= pad_in;
      out_ff    <= out_in;
   end

endmodule

// File: rtl/itoa_checker.sv
`timescale 1ns / 1ps

module itoa_checker import itoa_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         empty,
   input logic         pop,
   input itoa_rsp_type rsp_data
);

   logic is_minus;
   logic is_digit;
   logic is_letter;

   assign is_minus  = (rsp_data.character == CHAR_MINUS);
   assign is_digit  = (rsp_data.character >= CHAR_ZERO) &&
                      (rsp_data.character <= CHAR_ZERO + 8'd9);
   assign is_letter = ((rsp_data.character >= CHAR_UPPER_A) &&
                       (rsp_data.character <= CHAR_UPPER_A + 8'd5)) ||
                      ((rsp_data.character >= CHAR_LOWER_A) &&
                       (rsp_data.character <= CHAR_LOWER_A + 8'd5));

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("response not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("stalled response changed");

   a_charset: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (is_digit || is_letter || is_minus ||
                  (rsp_data.character == CHAR_SPACE)))
      else $error("character outside the output set");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && is_minus) |-> !rsp_data.last)
      else $error("minus marked as last");

   a_single_minus: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && is_minus) |=> (empty || !is_minus))
      else $error("two minus signs in a row");

endmodule

bind integer_to_ascii_padded_top itoa_checker u_itoa_checker (.*);
